// File: rtl/core/pcof_pkg.sv
`default_nettype none
package pcof_pkg;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned RegBits = 23;
  localparam int unsigned CountBits = 6;

  localparam logic [1:0] RegNeighborRadius = 2'd0;
  localparam logic [1:0] RegMinNeighbors = 2'd1;
  localparam logic [1:0] RegMaxDistance = 2'd2;

  localparam logic [1:0] VerdictKept = 2'd0;
  localparam logic [1:0] VerdictFar = 2'd1;
  localparam logic [1:0] VerdictSparse = 2'd2;

  typedef enum logic [3:0] {
    StLoad, StDivInit, StDiv, StLimits, StPointRd, StGateAxis, StGateCmp,
    StPairRd, StPairAxis, StPairCmp, StEmit
  } state_e;
endpackage
`default_nettype wire

// File: rtl/core/point_cloud_outlier_filter.sv
`default_nettype none
// Point cloud outlier filter. Points are loaded one transfer per cycle into an
// internal store until a transfer with last_point_i set, or until the store holds
// MAX_POINTS points. The block then stops taking points, forms the centroid with
// a bit-serial divider, and judges each stored point in load order: first the
// centroid gate (a store read, three axis steps and a compare), then, for a point
// inside the gate, the neighbor count with a store read, three axis steps and a
// compare per other stored point, all through one shared square unit. One verdict
// transfer per stored point leaves on the result port; the next cloud is accepted
// after the final verdict is taken. Registers must be written through cfg_we_i
// only while the block is idle; the block itself does not enforce this.
module point_cloud_outlier_filter #(
  parameter int unsigned MAX_POINTS = pcof_pkg::MaxPoints,
  parameter int unsigned COORD_BITS = pcof_pkg::CoordBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [pcof_pkg::RegBits-1:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic signed [COORD_BITS-1:0] point_z_i,
  input  wire logic last_point_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [pcof_pkg::CountBits-1:0] out_index_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic signed [COORD_BITS-1:0] out_z_o,
  output logic [1:0] verdict_o,
  output logic [pcof_pkg::CountBits-1:0] neighbor_total_o,
  output logic last_verdict_o
);
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned SW = COORD_BITS + 7; // sum width
  localparam int unsigned AW = SW + 1;         // operand width of the square unit
  localparam int unsigned QW = 2 * COORD_BITS + 4;
  localparam int unsigned CB = pcof_pkg::CountBits;

  // The store holds x, y and z side by side in one word per point.
  logic [3*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [3*COORD_BITS-1:0] rd_q;

  pcof_pkg::state_e state_q, state_d;
  logic [NW-1:0] count_q;
  logic [IW-1:0] i_q, j_q;
  logic [1:0] axis_q;
  logic signed [SW-1:0] sum_q [3];
  logic signed [SW-1:0] cen_q [3];
  logic [pcof_pkg::RegBits-1:0] radius_q, gate_q;
  logic [CB-1:0] min_q, total_q;
  logic [QW-1:0] r2_q, g2_q;
  logic [3*COORD_BITS-1:0] self_q;

  // Bit-serial divider of |sum| by count, one quotient bit a cycle.
  logic [SW-1:0] dvd_q;
  logic [NW-1:0] rem_q;
  logic [5:0] dcnt_q;
  logic dneg_q;
  logic [NW:0] trial;

  logic sq_clear, sq_en;
  logic signed [AW-1:0] sq_a, sq_b;
  logic [QW-1:0] sq_acc;

  logic out_valid_q;
  logic [1:0] verdict_q;

  pcof_sq_unit #(.CoordBits(COORD_BITS)) u_sq (
    .clk_i, .clear_i(sq_clear), .en_i(sq_en), .a_i(sq_a), .b_i(sq_b), .acc_o(sq_acc)
  );

  function automatic logic signed [AW-1:0] coord(input logic [3*COORD_BITS-1:0] w,
                                                 input logic [1:0] ax);
    logic signed [COORD_BITS-1:0] c;
    begin
      c = (ax == 2'd0) ? w[COORD_BITS-1:0] :
          (ax == 2'd1) ? w[2*COORD_BITS-1:COORD_BITS] : w[3*COORD_BITS-1:2*COORD_BITS];
      coord = AW'(c);
    end
  endfunction

  logic signed [AW-1:0] cen_sel;
  always_comb begin
    cen_sel = AW'(cen_q[0]);
    if (axis_q == 2'd1) cen_sel = AW'(cen_q[1]);
    if (axis_q == 2'd2) cen_sel = AW'(cen_q[2]);
  end

  always_comb begin
    trial = {rem_q, dvd_q[SW-1]} - {1'b0, count_q};
    sq_clear = 1'b0;
    sq_en = 1'b0;
    sq_a = coord(self_q, axis_q);
    sq_b = coord(rd_q, axis_q);
    state_d = state_q;
    unique case (state_q)
      pcof_pkg::StLoad: begin
        if (in_valid_i && (last_point_i || (count_q == NW'(MAX_POINTS - 1)))) begin
          state_d = pcof_pkg::StDivInit;
        end
      end
      pcof_pkg::StDivInit: state_d = pcof_pkg::StDiv;
      pcof_pkg::StDiv: begin
        if (dcnt_q == 6'(SW - 1)) begin
          state_d = (axis_q == 2'd2) ? pcof_pkg::StLimits : pcof_pkg::StDivInit;
        end
      end
      pcof_pkg::StLimits: begin
        sq_clear = 1'b1;
        state_d = pcof_pkg::StPointRd;
      end
      pcof_pkg::StPointRd: begin
        sq_clear = 1'b1;
        state_d = pcof_pkg::StGateAxis;
      end
      pcof_pkg::StGateAxis: begin
        sq_en = 1'b1;
        sq_a = coord(rd_q, axis_q);
        sq_b = cen_sel;
        if (axis_q == 2'd2) state_d = pcof_pkg::StGateCmp;
      end
      pcof_pkg::StGateCmp: begin
        sq_clear = 1'b1;
        if (sq_acc > g2_q) state_d = pcof_pkg::StEmit;
        else state_d = pcof_pkg::StPairRd;
      end
      pcof_pkg::StPairRd: begin
        sq_clear = 1'b1;
        if (j_q == i_q) begin
          state_d = (NW'(j_q) == count_q - 1'b1) ? pcof_pkg::StEmit : pcof_pkg::StPairRd;
        end else begin
          state_d = pcof_pkg::StPairAxis;
        end
      end
      pcof_pkg::StPairAxis: begin
        sq_en = 1'b1;
        if (axis_q == 2'd2) state_d = pcof_pkg::StPairCmp;
      end
      pcof_pkg::StPairCmp: begin
        sq_clear = 1'b1;
        state_d = (NW'(j_q) == count_q - 1'b1) ? pcof_pkg::StEmit : pcof_pkg::StPairRd;
      end
      pcof_pkg::StEmit: begin
        if (out_valid_q && out_ready_i) begin
          state_d = (NW'(i_q) == count_q - 1'b1) ? pcof_pkg::StLoad : pcof_pkg::StPointRd;
        end
      end
      default: state_d = pcof_pkg::StLoad;
    endcase
  end

  assign in_ready_o = (state_q == pcof_pkg::StLoad);

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mem[count_q[IW-1:0]] <= {point_z_i, point_y_i, point_x_i};
    end
    // The store is read at the point under judgment or at its partner. The
    // point under judgment is held while its three axes are gated.
    if (state_q == pcof_pkg::StPointRd || state_q == pcof_pkg::StLimits ||
        state_q == pcof_pkg::StGateAxis) begin
      rd_q <= mem[i_q];
    end else begin
      rd_q <= mem[j_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcof_pkg::StLoad;
      count_q <= '0;
      i_q <= '0;
      j_q <= '0;
      axis_q <= '0;
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
      for (int k = 0; k < 3; k++) cen_q[k] <= '0;
      radius_q <= pcof_pkg::RegBits'(5120);
      min_q <= CB'(20);
      gate_q <= pcof_pkg::RegBits'(12288);
      r2_q <= '0;
      g2_q <= '0;
      self_q <= '0;
      out_valid_q <= 1'b0;
      verdict_q <= pcof_pkg::VerdictKept;
      total_q <= '0;
      dcnt_q <= '0;
      dvd_q <= '0;
      rem_q <= '0;
      dneg_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pcof_pkg::RegNeighborRadius: radius_q <= cfg_data_i;
          pcof_pkg::RegMinNeighbors: min_q <= cfg_data_i[CB-1:0];
          pcof_pkg::RegMaxDistance: gate_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        pcof_pkg::StLoad: begin
          axis_q <= '0;
          if (in_valid_i) begin
            count_q <= count_q + 1'b1;
            sum_q[0] <= sum_q[0] + SW'(point_x_i);
            sum_q[1] <= sum_q[1] + SW'(point_y_i);
            sum_q[2] <= sum_q[2] + SW'(point_z_i);
          end
        end
        pcof_pkg::StDivInit: begin
          dcnt_q <= '0;
          dneg_q <= sum_q[axis_q][SW-1];
          dvd_q <= sum_q[axis_q][SW-1] ? SW'(-sum_q[axis_q]) : sum_q[axis_q];
          rem_q <= '0;
        end
        pcof_pkg::StDiv: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (!trial[NW]) begin
            rem_q <= trial[NW-1:0];
            dvd_q <= {dvd_q[SW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[NW-2:0], dvd_q[SW-1]};
            dvd_q <= {dvd_q[SW-2:0], 1'b0};
          end
          if (dcnt_q == 6'(SW - 1)) begin
            cen_q[axis_q] <= dneg_q ?
              -$signed({dvd_q[SW-2:0], ~trial[NW]}) : $signed({dvd_q[SW-2:0], ~trial[NW]});
            axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
          end
        end
        pcof_pkg::StLimits: begin
          r2_q <= QW'(radius_q * radius_q);
          g2_q <= QW'(gate_q * gate_q);
          i_q <= '0;
          for (int k = 0; k < 3; k++) sum_q[k] <= '0;
        end
        pcof_pkg::StPointRd: begin
          axis_q <= '0;
          total_q <= '0;
          j_q <= '0;
        end
        pcof_pkg::StGateAxis: begin
          axis_q <= axis_q + 1'b1;
          self_q <= rd_q;
        end
        pcof_pkg::StGateCmp: begin
          axis_q <= '0;
          if (sq_acc > g2_q) begin
            verdict_q <= pcof_pkg::VerdictFar;
            out_valid_q <= 1'b1;
          end
        end
        pcof_pkg::StPairRd: begin
          axis_q <= '0;
          if (j_q == i_q) begin
            if (NW'(j_q) == count_q - 1'b1) begin
              verdict_q <= (total_q >= min_q) ? pcof_pkg::VerdictKept : pcof_pkg::VerdictSparse;
              out_valid_q <= 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        pcof_pkg::StPairAxis: axis_q <= axis_q + 1'b1;
        pcof_pkg::StPairCmp: begin
          if (NW'(j_q) == count_q - 1'b1) begin
            verdict_q <= ((total_q + CB'(sq_acc <= r2_q)) >= min_q) ?
                         pcof_pkg::VerdictKept : pcof_pkg::VerdictSparse;
            out_valid_q <= 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
          if (sq_acc <= r2_q) total_q <= total_q + 1'b1;
        end
        pcof_pkg::StEmit: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
            i_q <= i_q + 1'b1;
            if (NW'(i_q) == count_q - 1'b1) count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = CB'(i_q);
  assign out_x_o = self_q[COORD_BITS-1:0];
  assign out_y_o = self_q[2*COORD_BITS-1:COORD_BITS];
  assign out_z_o = self_q[3*COORD_BITS-1:2*COORD_BITS];
  assign verdict_o = verdict_q;
  assign neighbor_total_o = (verdict_q == pcof_pkg::VerdictFar) ? '0 : total_q;
  assign last_verdict_o = (NW'(i_q) == count_q - 1'b1);
endmodule
`default_nettype wire

// File: rtl/core/pcof_sq_unit.sv
`default_nettype none
// Shared square unit: registered absolute difference squared, accumulated.
module pcof_sq_unit #(
  parameter int unsigned CoordBits = pcof_pkg::CoordBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   clear_i,
  input  wire logic                   en_i,
  input  wire logic signed [CoordBits+7:0] a_i,
  input  wire logic signed [CoordBits+7:0] b_i,
  output logic [2*CoordBits+3:0]      acc_o
);
  localparam int unsigned DW = CoordBits + 1;
  logic signed [CoordBits+8:0] diff;
  logic [DW-1:0] mag;
  logic [2*CoordBits+3:0] acc_q;
  always_comb begin
    diff = {a_i[CoordBits+7], a_i} - {b_i[CoordBits+7], b_i};
    mag = diff[CoordBits+8] ? DW'(-diff) : DW'(diff);
  end
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_q + (2*CoordBits+4)'(mag * mag);
    end
  end
  assign acc_o = acc_q;
endmodule
`default_nettype wire

// File: tb/sv/tb_point_cloud_outlier_filter.sv
`default_nettype none
// Testbench for the point cloud outlier filter. Points are pushed through the
// valid/ready input channel in bursts with random gaps, and verdicts are taken
// from the result channel while the receiver at times stalls on its own pattern. A
// behavioral copy of the filter runs alongside: it keeps its own store and
// sums, and when a cloud closes it queues one expected verdict per stored point.
// Every verdict transfer is compared field by field against the oldest entry.
module tb_point_cloud_outlier_filter;
  import pcof_pkg::*;

  localparam int unsigned NumRows = 20;
  localparam int unsigned IdleLimit = 200000;

  // One expected verdict transfer.
  typedef struct {
    logic [CountBits-1:0] index;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
    logic [1:0] verdict;
    logic [CountBits-1:0] total;
    logic last;
  } verdict_t;

  // One point of the directed table. A check value of 2'd3 means the verdict
  // is left to the behavioral filter alone.
  typedef struct {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
    logic last;
    logic [1:0] check;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [RegBits-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [CoordBits-1:0] point_x_i;
  logic signed [CoordBits-1:0] point_y_i;
  logic signed [CoordBits-1:0] point_z_i;
  logic last_point_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [CountBits-1:0] out_index_o;
  logic signed [CoordBits-1:0] out_x_o;
  logic signed [CoordBits-1:0] out_y_o;
  logic signed [CoordBits-1:0] out_z_o;
  logic [1:0] verdict_o;
  logic [CountBits-1:0] neighbor_total_o;
  logic last_verdict_o;

  point_cloud_outlier_filter DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .point_x_i,
    .point_y_i,
    .point_z_i,
    .last_point_i,
    .out_valid_o,
    .out_ready_i,
    .out_index_o,
    .out_x_o,
    .out_y_o,
    .out_z_o,
    .verdict_o,
    .neighbor_total_o,
    .last_verdict_o
  );

  // Shadow copy of the registers and the cloud being loaded.
  logic [RegBits-1:0] radius_q;
  logic [CountBits-1:0] min_count_q;
  logic [RegBits-1:0] gate_q;
  logic signed [CoordBits-1:0] cloud_x [MaxPoints];
  logic signed [CoordBits-1:0] cloud_y [MaxPoints];
  logic signed [CoordBits-1:0] cloud_z [MaxPoints];
  int unsigned cloud_len;
  longint sum_x, sum_y, sum_z;

  verdict_t pending_verdicts[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit timed_out;
  bit out_stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned squared_distance(longint ax, longint ay, longint az,
                                                       longint bx, longint by, longint bz);
    longint dx, dy, dz;
    dx = ax - bx;
    dy = ay - by;
    dz = az - bz;
    return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
  endfunction

  // Mirrors one accepted point transfer. When the cloud closes, at the last
  // flag or when the store fills, every stored point is judged and queued.
  task automatic absorb_point(input logic signed [CoordBits-1:0] x,
                              input logic signed [CoordBits-1:0] y,
                              input logic signed [CoordBits-1:0] z,
                              input logic last);
    longint cx, cy, cz;
    longint unsigned r2, g2;
    int unsigned total;
    verdict_t v;
    cloud_x[cloud_len] = x;
    cloud_y[cloud_len] = y;
    cloud_z[cloud_len] = z;
    cloud_len++;
    sum_x += x;
    sum_y += y;
    sum_z += z;
    if (!last && cloud_len < MaxPoints) return;
    // SystemVerilog integer division truncates toward zero, as the block does.
    cx = sum_x / longint'(cloud_len);
    cy = sum_y / longint'(cloud_len);
    cz = sum_z / longint'(cloud_len);
    r2 = longint'(radius_q) * longint'(radius_q);
    g2 = longint'(gate_q) * longint'(gate_q);
    for (int unsigned i = 0; i < cloud_len; i++) begin
      total = 0;
      v.index = CountBits'(i);
      v.x = cloud_x[i];
      v.y = cloud_y[i];
      v.z = cloud_z[i];
      v.last = (i + 1 == cloud_len);
      if (squared_distance(cloud_x[i], cloud_y[i], cloud_z[i], cx, cy, cz) > g2) begin
        v.verdict = VerdictFar;
      end else begin
        for (int unsigned j = 0; j < cloud_len; j++) begin
          if (j != i && squared_distance(cloud_x[i], cloud_y[i], cloud_z[i],
                                         cloud_x[j], cloud_y[j], cloud_z[j]) <= r2) begin
            total++;
          end
        end
        v.verdict = (total >= min_count_q) ? VerdictKept : VerdictSparse;
      end
      v.total = CountBits'(total);
      pending_verdicts.insert(pending_verdicts.size(), v);
    end
    cloud_len = 0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
  endtask

  // Registers are only written with nothing in flight, so the shadow copy is
  // updated at the same edge as the block.
  task automatic write_register(input logic [1:0] index, input logic [RegBits-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      RegNeighborRadius: radius_q = value;
      RegMinNeighbors: min_count_q = value[CountBits-1:0];
      RegMaxDistance: gate_q = value;
      default: ;
    endcase
  endtask

  // Drives one point and holds it until the transfer happens. A random gap
  // ends a burst now and then.
  task automatic send_point(input logic signed [CoordBits-1:0] x,
                            input logic signed [CoordBits-1:0] y,
                            input logic signed [CoordBits-1:0] z,
                            input logic last);
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    last_point_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_point(x, y, z, last);
    if ($urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Waits until every expected verdict has been taken, then lets the block
  // settle before anything else happens.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // A random coordinate, mostly clustered so that neighbor counts vary,
  // sometimes spread across the full range.
  function automatic logic signed [CoordBits-1:0] random_coord(int unsigned spread);
    if ($urandom_range(0, 9) == 0) return CoordBits'($urandom);
    return CoordBits'($signed($urandom_range(0, 2 * spread)) - $signed(spread));
  endfunction

  task automatic random_cloud(input int unsigned len, input int unsigned spread);
    for (int unsigned i = 0; i < len; i++) begin
      send_point(random_coord(spread), random_coord(spread), random_coord(spread),
                 i + 1 == len);
    end
  endtask

  // Result channel: the receiver stalls either in a random pattern or not at all.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= out_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // Compares every verdict transfer with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected verdict index %0d", out_index_o);
      end else begin
        e = pending_verdicts.pop_front();
        if (out_index_o !== e.index || out_x_o !== e.x || out_y_o !== e.y ||
            out_z_o !== e.z || verdict_o !== e.verdict ||
            neighbor_total_o !== e.total || last_verdict_o !== e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("verdict mismatch: exp idx %0d xyz %0d %0d %0d v %0d n %0d l %0d",
                     e.index, e.x, e.y, e.z, e.verdict, e.total, e.last);
            $display("                  got idx %0d xyz %0d %0d %0d v %0d n %0d l %0d",
                     out_index_o, out_x_o, out_y_o, out_z_o, verdict_o,
                     neighbor_total_o, last_verdict_o);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on either channel while work is pending.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni ||
        (!in_valid_i && pending_verdicts.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      timed_out = 1'b1;
      $display("point_cloud_outlier_filter regression: fail");
      $finish;
    end
  end

  row_t rows [NumRows];
  int unsigned checked_row;

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegNeighborRadius;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    last_point_i = 1'b0;
    out_stall_mode = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    radius_q = 5120;
    min_count_q = 20;
    gate_q = 12288;
    cloud_len = 0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;

    // Directed table at reset settings. A lone point sits on its own centroid
    // and has no neighbors, so it is judged too sparse. The extreme pair sums
    // to -1 per axis, which truncates toward zero to a centroid of 0, and both
    // ends lie far outside the gate. The other rows exercise clusters and are
    // left to the predictor.
    rows = '{
      '{24'sd0, 24'sd0, 24'sd0, 1'b1, VerdictSparse},
      '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b0, VerdictFar},
      '{-24'sh800000, -24'sh800000, -24'sh800000, 1'b1, VerdictFar},
      '{24'sd100, -24'sd100, 24'sd0, 1'b0, 2'd3},
      '{24'sd200, 24'sd50, -24'sd30, 1'b0, 2'd3},
      '{-24'sd150, 24'sd0, 24'sd10, 1'b0, 2'd3},
      '{24'sd40000, 24'sd0, 24'sd0, 1'b1, 2'd3},
      '{24'sd5120, 24'sd0, 24'sd0, 1'b0, 2'd3},
      '{24'sd0, 24'sd0, 24'sd0, 1'b0, 2'd3},
      '{-24'sd5120, 24'sd0, 24'sd0, 1'b1, 2'd3},
      '{24'sd12288, 24'sd0, 24'sd0, 1'b0, 2'd3},
      '{-24'sd12288, 24'sd0, 24'sd0, 1'b1, 2'd3},
      '{24'sh555555, -24'sh2aaaab, 24'sd1, 1'b0, 2'd3},
      '{-24'sh555556, 24'sh2aaaaa, -24'sd1, 1'b1, 2'd3},
      '{24'sd1, 24'sd2, 24'sd3, 1'b0, 2'd3},
      '{24'sd1, 24'sd2, 24'sd3, 1'b0, 2'd3},
      '{24'sd1, 24'sd2, 24'sd4, 1'b0, 2'd3},
      '{24'sd2, 24'sd2, 24'sd3, 1'b0, 2'd3},
      '{24'sd1, 24'sd3, 24'sd3, 1'b0, 2'd3},
      '{24'sd9, 24'sd9, 24'sd9, 1'b1, 2'd3}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    checked_row = 0;
    foreach (rows[r]) begin
      send_point(rows[r].x, rows[r].y, rows[r].z, rows[r].last);
      if (r < 3 && pending_verdicts.size() > checked_row) begin
        if (pending_verdicts[pending_verdicts.size() - 1].verdict !== rows[r].check) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("row %0d: predicted verdict off table", r);
        end
      end
      if (r == 2) begin
        // Drain now so the small clouds leave before the cluster rows load.
        drain();
      end
    end
    drain();

    // Small radius and minimum: tight cluster with a mix of verdicts.
    write_register(RegNeighborRadius, 23'd300);
    write_register(RegMinNeighbors, 23'd2);
    write_register(RegMaxDistance, 23'd2000);
    out_stall_mode = 1'b1;
    for (int k = 0; k < 6; k++) random_cloud($urandom_range(2, 12), 600);
    drain();

    // Zero radius and zero minimum: every point inside the gate is kept.
    write_register(RegNeighborRadius, 23'd0);
    write_register(RegMinNeighbors, 23'd0);
    write_register(RegMaxDistance, 23'h7fffff);
    out_stall_mode = 1'b0;
    for (int k = 0; k < 4; k++) random_cloud($urandom_range(1, 8), 50);
    drain();

    // Largest radius and minimum, zero gate: almost everything is too far.
    write_register(RegNeighborRadius, 23'h7fffff);
    write_register(RegMinNeighbors, 23'h3f);
    write_register(RegMaxDistance, 23'd0);
    out_stall_mode = 1'b1;
    for (int k = 0; k < 4; k++) random_cloud($urandom_range(1, 8), 20);
    drain();

    // One full store without a last flag: the filling point closes the cloud.
    write_register(RegNeighborRadius, 23'd4000);
    write_register(RegMinNeighbors, 23'd3);
    write_register(RegMaxDistance, 23'd30000);
    for (int unsigned i = 0; i < MaxPoints; i++) begin
      send_point(random_coord(8000), random_coord(8000), random_coord(8000), 1'b0);
    end
    drain();

    // Random settings with modest clouds: four rounds of three clouds each.
    for (int k = 0; k < 4; k++) begin
      write_register(RegNeighborRadius, 23'($urandom_range(0, 9000)));
      write_register(RegMinNeighbors, 23'($urandom_range(0, 6)));
      write_register(RegMaxDistance, 23'($urandom_range(500, 20000)));
      out_stall_mode = $urandom_range(0, 1);
      for (int c = 0; c < 3; c++) random_cloud($urandom_range(1, 10), 6000);
      drain();
    end

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("point_cloud_outlier_filter regression: pass");
    end else begin
      $display("point_cloud_outlier_filter regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
